// ----- hdl/wavp_pkg.sv -----
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types and constants for the WAV header parser: word layouts of the
// byte channel and the result channel, RIFF tags and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wavp_pkg;

  // Input word: one file byte with its framing
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] file_length;
    logic        load_failed;
  } wavp_in_t;

  // Result word: one per input byte
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        done_res;
    logic [3:0]  status;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [15:0] play_mask;
    logic [31:0] payload_length;
  } wavp_out_t;

  // Chunk tags, little-endian as they arrive
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Size limits
  localparam logic [31:0] WAV_MIN_LEN = 32'd44;
  localparam logic [32:0] WALK_START  = 33'd12;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [31:0] SHORT_LEN   = 32'd4;

  // Player format mask bits
  localparam logic [15:0] MASK_PLAY   = 16'h1000;
  localparam logic [15:0] MASK_BITS16 = 16'h0001;
  localparam logic [15:0] MASK_MONO   = 16'h0010;
  localparam logic [15:0] MASK_STEREO = 16'h0020;

  // Final status codes
  localparam logic [3:0] ST_BUSY     = 4'd0;
  localparam logic [3:0] ST_OK       = 4'd1;
  localparam logic [3:0] ST_EMPTY    = 4'd2;
  localparam logic [3:0] ST_FAILED   = 4'd3;
  localparam logic [3:0] ST_SHORT    = 4'd4;
  localparam logic [3:0] ST_NOT_RIFF = 4'd5;
  localparam logic [3:0] ST_TOO_SMALL = 4'd6;
  localparam logic [3:0] ST_BAD_FMT  = 4'd7;
  localparam logic [3:0] ST_NO_FMT   = 4'd8;
  localparam logic [3:0] ST_NO_DATA  = 4'd9;

endpackage

`default_nettype wire

// ----- hdl/wavp_in_reg.sv -----
// ----------------------------------------------------------------------------
// wavp_in_reg
// Input register: captures one byte word and holds it until the parser
// takes it into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wavp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wavp_pkg::wavp_in_t in_data,
  input  wire logic              advance,
  output logic                   s1_valid,
  output wavp_pkg::wavp_in_t     s1_data
);
  import wavp_pkg::*;

  logic     valid_r, valid_nxt;
  wavp_in_t data_r;
  logic     take;

  // Stall only while a held word cannot move on
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  // Fill on accept, drain on advance
  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

`default_nettype wire

// ----- hdl/wavp_parse.sv -----
// ----------------------------------------------------------------------------
// wavp_parse
// Parse state and per-byte logic: header checks, chunk walk, fmt field
// capture, chunk skip and payload pass-through. State advances on step.
// ----------------------------------------------------------------------------
`default_nettype none

module wavp_parse (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire wavp_pkg::wavp_in_t item,
  output wavp_pkg::wavp_out_t     result
);
  import wavp_pkg::*;

  // Parse phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_CHDR = 3'd2;
  localparam logic [2:0] PH_FMT  = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_PAY  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  // Chunk kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [32:0] WALK_LAST = WALK_START - 33'd1;

  logic [2:0]  phase_r,  phase_nxt,  phase_b;
  logic [32:0] offset_r, offset_nxt, offset_b;
  logic [31:0] tag_r,    tag_nxt,    tag_b;
  logic [31:0] len_r,    len_nxt,    len_b;
  logic [31:0] skip_r,   skip_nxt,   skip_b;
  logic [31:0] fmtlen_r, fmtlen_nxt, fmtlen_b;
  logic [15:0] format_r, format_nxt, format_b;
  logic [15:0] chan_r,   chan_nxt,   chan_b;
  logic [31:0] rate_r,   rate_nxt,   rate_b;
  logic [15:0] bits_r,   bits_nxt,   bits_b;
  logic [31:0] audio_r,  audio_nxt,  audio_b;
  logic [3:0]  status_r, status_nxt, status_b;
  logic [2:0]  hdr_r,    hdr_nxt,    hdr_b;
  logic [31:0] body_r,   body_nxt,   body_b;
  logic [1:0]  kind_r,   kind_nxt,   kind_b;
  logic [31:0] total_r,  total_nxt,  total_b;

  logic        first;
  logic [32:0] next_pos;
  logic [32:0] flen;
  logic [33:0] flen_w;
  logic [31:0] tag_sh;
  logic [31:0] len_sh;
  logic        walk_end;
  logic [33:0] chunk_end;
  logic        fmt_over;
  logic        data_over;
  logic        next_past;
  logic [32:0] data_tail;
  logic [31:0] data_len;
  logic        skip_end;
  logic        body_last;
  logic        done;
  logic        pv;
  logic [15:0] mask;

  // Start from cleared state on the first byte of a file
  assign first    = item.first_byte;
  assign phase_b  = first ? PH_HEAD : phase_r;
  assign offset_b = first ? 33'd0 : offset_r;
  assign tag_b    = first ? 32'd0 : tag_r;
  assign len_b    = first ? 32'd0 : len_r;
  assign skip_b   = first ? 32'd0 : skip_r;
  assign fmtlen_b = first ? 32'd0 : fmtlen_r;
  assign format_b = first ? 16'd0 : format_r;
  assign chan_b   = first ? 16'd1 : chan_r;
  assign rate_b   = first ? 32'd0 : rate_r;
  assign bits_b   = first ? 16'd0 : bits_r;
  assign audio_b  = first ? 32'd0 : audio_r;
  assign status_b = first ? ST_BUSY : status_r;
  assign hdr_b    = first ? 3'd0 : hdr_r;
  assign body_b   = first ? 32'd0 : body_r;
  assign kind_b   = first ? KIND_OTHER : kind_r;
  assign total_b  = first ? 32'd0 : total_r;

  // Shift in the new byte, low byte first
  assign tag_sh = {item.data_byte, tag_b[31:8]};
  assign len_sh = {item.data_byte, len_b[31:8]};

  // Position arithmetic, wide enough never to wrap
  assign next_pos  = offset_b + 33'd1;
  assign flen      = {1'b0, item.file_length};
  assign flen_w    = {2'b00, item.file_length};
  assign walk_end  = ({1'b0, next_pos} + 34'd7) >= flen_w;
  assign chunk_end = {1'b0, next_pos} + {2'b00, len_sh};
  assign fmt_over  = chunk_end >= flen_w;
  assign data_over = chunk_end > flen_w;
  assign skip_end  = (chunk_end + 34'd7) >= flen_w;
  assign next_past = next_pos > flen;
  assign data_tail = flen - next_pos;
  assign body_last = ({1'b0, body_b} + 33'd1) >= {1'b0, fmtlen_b};

  // Clamp the data chunk to the file end
  always_comb begin
    if (!data_over) begin
      data_len = len_sh;
    end else if (next_past) begin
      data_len = 32'd0;
    end else begin
      data_len = data_tail[31:0];
    end
  end

  // Advance the parse by one byte
  always_comb begin
    phase_nxt  = phase_b;
    offset_nxt = offset_b;
    tag_nxt    = tag_b;
    len_nxt    = len_b;
    skip_nxt   = skip_b;
    fmtlen_nxt = fmtlen_b;
    format_nxt = format_b;
    chan_nxt   = chan_b;
    rate_nxt   = rate_b;
    bits_nxt   = bits_b;
    audio_nxt  = audio_b;
    status_nxt = status_b;
    hdr_nxt    = hdr_b;
    body_nxt   = body_b;
    kind_nxt   = kind_b;
    total_nxt  = total_b;
    done       = 1'b0;
    pv         = 1'b0;

    if (phase_b >= PH_HEAD && phase_b <= PH_SKIP) begin
      if (item.load_failed) begin
        status_nxt = ST_FAILED;
        phase_nxt  = PH_DONE;
        done       = 1'b1;
      end else begin
        tag_nxt    = tag_sh;
        offset_nxt = next_pos;
        unique case (phase_b)
          PH_HEAD: begin
            priority if (offset_b == 33'd0 && item.file_length < SHORT_LEN) begin
              status_nxt = ST_SHORT;
              phase_nxt  = PH_DONE;
              done       = 1'b1;
            end else if (offset_b == 33'd3) begin
              priority if (tag_sh != TAG_RIFF) begin
                status_nxt = ST_NOT_RIFF;
                phase_nxt  = PH_DONE;
                done       = 1'b1;
              end else if (item.file_length <= WAV_MIN_LEN) begin
                status_nxt = ST_TOO_SMALL;
                phase_nxt  = PH_DONE;
                done       = 1'b1;
              end else begin
              end
            end else if (offset_b == WALK_LAST) begin
              if (walk_end) begin
                status_nxt = ST_NO_DATA;
                phase_nxt  = PH_DONE;
                done       = 1'b1;
              end else begin
                phase_nxt = PH_CHDR;
                hdr_nxt   = 3'd0;
              end
            end else begin
            end
          end
          PH_CHDR: begin
            if (!hdr_b[2]) begin
              // Tag bytes: classify on the last one
              hdr_nxt = hdr_b + 3'd1;
              if (hdr_b == 3'd3) begin
                priority if (tag_sh == TAG_FMT && fmtlen_b == 32'd0) begin
                  kind_nxt = KIND_FMT;
                end else if (tag_sh == TAG_DATA) begin
                  kind_nxt = KIND_DATA;
                  if (fmtlen_b == 32'd0) begin
                    hdr_nxt    = hdr_b;
                    status_nxt = ST_NO_FMT;
                    phase_nxt  = PH_DONE;
                    done       = 1'b1;
                  end
                end else begin
                  kind_nxt = KIND_OTHER;
                end
              end
            end else begin
              // Length bytes: act on the last one
              len_nxt = len_sh;
              if (hdr_b != 3'd7) begin
                hdr_nxt = hdr_b + 3'd1;
              end else begin
                unique case (kind_b)
                  KIND_FMT: begin
                    if (len_sh < FMT_MIN_LEN || fmt_over) begin
                      status_nxt = ST_BAD_FMT;
                      phase_nxt  = PH_DONE;
                      done       = 1'b1;
                    end else begin
                      fmtlen_nxt = len_sh;
                      body_nxt   = 32'd0;
                      phase_nxt  = PH_FMT;
                    end
                  end
                  KIND_DATA: begin
                    total_nxt = data_len;
                    audio_nxt = data_len;
                    done      = 1'b1;
                    if (data_len == 32'd0) begin
                      status_nxt = ST_EMPTY;
                      phase_nxt  = PH_DONE;
                    end else begin
                      status_nxt = ST_OK;
                      phase_nxt  = PH_PAY;
                    end
                  end
                  default: begin
                    priority if (skip_end) begin
                      status_nxt = ST_NO_DATA;
                      phase_nxt  = PH_DONE;
                      done       = 1'b1;
                    end else if (len_sh == 32'd0) begin
                      hdr_nxt = 3'd0;
                    end else begin
                      skip_nxt  = len_sh;
                      phase_nxt = PH_SKIP;
                    end
                  end
                endcase
              end
            end
          end
          PH_FMT: begin
            // Capture fields at their last byte
            if (body_b == 32'd1) begin
              format_nxt = tag_sh[31:16];
            end else if (body_b == 32'd3) begin
              chan_nxt = tag_sh[31:16];
            end else if (body_b == 32'd7) begin
              rate_nxt = tag_sh;
            end else if (body_b == 32'd15) begin
              bits_nxt = tag_sh[31:16];
            end
            if (body_last) begin
              if (walk_end) begin
                status_nxt = ST_NO_DATA;
                phase_nxt  = PH_DONE;
                done       = 1'b1;
              end else begin
                phase_nxt = PH_CHDR;
                hdr_nxt   = 3'd0;
              end
            end else begin
              body_nxt = body_b + 32'd1;
            end
          end
          default: begin
            // Skip the rest of an unwanted chunk
            skip_nxt = skip_b - 32'd1;
            if (skip_b == 32'd1) begin
              phase_nxt = PH_CHDR;
              hdr_nxt   = 3'd0;
            end
          end
        endcase
      end
    end else if (phase_b == PH_PAY) begin
      // Pass a payload byte
      pv        = 1'b1;
      audio_nxt = audio_b - 32'd1;
      if (audio_b == 32'd1) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // Player format mask from the updated fields
  assign mask = MASK_PLAY | ((bits_nxt == 16'd8) ? 16'd0 : MASK_BITS16) |
                ((chan_nxt == 16'd1) ? MASK_MONO : MASK_STEREO);

  always_comb begin
    result.payload_byte   = pv ? item.data_byte : 8'd0;
    result.payload_valid  = pv;
    result.done_res       = done;
    result.status         = status_nxt;
    result.format_code    = format_nxt;
    result.channel_count  = chan_nxt;
    result.sample_rate    = rate_nxt;
    result.sample_bits    = bits_nxt;
    result.play_mask      = mask;
    result.payload_length = total_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      offset_r <= '0;
      tag_r    <= '0;
      len_r    <= '0;
      skip_r   <= '0;
      fmtlen_r <= '0;
      format_r <= '0;
      chan_r   <= 16'd1;
      rate_r   <= '0;
      bits_r   <= '0;
      audio_r  <= '0;
      status_r <= ST_BUSY;
      hdr_r    <= '0;
      body_r   <= '0;
      kind_r   <= KIND_OTHER;
      total_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      tag_r    <= tag_nxt;
      len_r    <= len_nxt;
      skip_r   <= skip_nxt;
      fmtlen_r <= fmtlen_nxt;
      format_r <= format_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      audio_r  <= audio_nxt;
      status_r <= status_nxt;
      hdr_r    <= hdr_nxt;
      body_r   <= body_nxt;
      kind_r   <= kind_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wav_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// wav_header_parser_top
// WAV header parser: walks a RIFF/WAV byte stream, captures the fmt fields
// and passes the clamped data payload, one result word per input byte.
// ----------------------------------------------------------------------------
// Each accepted byte waits in the input register; its result word then goes
// to the result register. One byte per cycle unless out_stall holds it; each
// byte updates the parse registers in a single pass between the two registers.
// Reset: synchronous, active low; clears both registers' valid flags and
// returns the parser to idle, where bytes before a first byte show busy.
`default_nettype none

module wav_header_parser_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wavp_pkg::wavp_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wavp_pkg::wavp_out_t      out_data
);
  import wavp_pkg::*;

  logic      advance;
  logic      s1_valid;
  wavp_in_t  s1_data;
  logic      step;
  wavp_out_t result;
  logic      out_valid_r, out_valid_nxt;
  wavp_out_t out_data_r;

  // Result register frees up when empty or being taken
  assign advance = !out_valid_r || !out_stall;
  assign step    = s1_valid && advance;

  wavp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  wavp_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_data),
    .result (result)
  );

  // Load on step, hold while stalled, drop once taken
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Payload bytes only flow after an audio-ok decision
  a_pay_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.payload_valid |-> out_data_r.status == ST_OK)
    else $error("payload byte without audio-ok status");

  // A decision never reports busy
  a_done_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> out_data_r.status != ST_BUSY)
    else $error("done flagged with busy status");

  // Non-payload words carry a zero byte
  a_pay_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.payload_valid |-> out_data_r.payload_byte == 8'd0)
    else $error("stray payload byte");

  // A parsed byte always lands in the result register
  a_step_lands : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("parsed byte lost");

  // Input stalls only when the result side is full and stalled
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && out_valid_r && out_stall)
    else $error("input stalled without back-pressure");

endmodule

`default_nettype wire
